@@ sv/sgwp_pkg.sv @@
package sgwp_pkg;

   // request function codes
   localparam logic [1:0] FUNC_STATE  = 2'd0;
   localparam logic [1:0] FUNC_JUMP   = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;   // unused code, ignored

   // control register indexes
   localparam logic [1:0] CSR_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_MIN_GAP   = 2'd1;
   localparam logic [1:0] CSR_FIRST_IDX = 2'd2;

   // plan outcome codes
   localparam logic PLANNED     = 1'b1;
   localparam logic NOT_PLANNED = 1'b0;

   // fixed field widths
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 47;
   localparam int GAP_BITS       = 47;
   localparam int INDEX_BITS     = 32;
   localparam int STATE_OUT_BITS = 10;
   localparam int OVERLAP_BITS   = 7;

   // parameter defaults
   localparam int STATE_DEPTH_DEF = 1024;
   localparam int JUMP_DEPTH_DEF  = 64;
   localparam int TIME_BITS_DEF   = 48;

endpackage

@@ sv/sample_gap_window_planner_unit.sv @@
// a window is planned by two binary searches over the single state read port, then a jump window scan
// throughput: one word per cycle outside planning, req_stall is high while planning and while
// a finished window waits on rsp_stall
// reset: synchronous active high; clears fills, anchor, counters and control registers, tables are not cleared
module sample_gap_window_planner_unit #(
   parameter int STATE_DEPTH = sgwp_pkg::STATE_DEPTH_DEF,
   parameter int JUMP_DEPTH  = sgwp_pkg::JUMP_DEPTH_DEF,
   parameter int TIME_BITS   = sgwp_pkg::TIME_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // control register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sgwp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sgwp_pkg::CSR_DATA_BITS-1:0]     csr_data,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_func,
   input  logic [TIME_BITS-1:0]                   req_item_time,
   input  logic [TIME_BITS-1:0]                   req_window_end,
   input  logic                                   req_sample_usable,
   input  logic                                   req_time_valid,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sgwp_pkg::INDEX_BITS-1:0]        rsp_window_number,
   output logic [sgwp_pkg::INDEX_BITS-1:0]        rsp_pre_sample,
   output logic [sgwp_pkg::INDEX_BITS-1:0]        rsp_post_sample,
   output logic [TIME_BITS-1:0]                   rsp_pre_time,
   output logic [TIME_BITS-1:0]                   rsp_post_time,
   output logic [TIME_BITS-1:0]                   rsp_gap_length,
   output logic [sgwp_pkg::STATE_OUT_BITS-1:0]    rsp_pre_state,
   output logic [sgwp_pkg::STATE_OUT_BITS-1:0]    rsp_post_state,
   output logic [sgwp_pkg::INDEX_BITS-1:0]        rsp_rejected_between,
   output logic [sgwp_pkg::OVERLAP_BITS-1:0]      rsp_overlap_count,
   output logic                                   rsp_planned,
   output logic [sgwp_pkg::STATE_OUT_BITS-1:0]    rsp_interior_count
);

   localparam int IB = sgwp_pkg::INDEX_BITS;
   localparam int SB = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;   // state address bits
   localparam int FB = SB + 1;                                        // state fill bits
   localparam int JB = (JUMP_DEPTH > 1) ? $clog2(JUMP_DEPTH) : 1;     // jump address bits
   localparam int JF = JB + 1;                                        // jump fill bits
   localparam int CW = (TIME_BITS > sgwp_pkg::GAP_BITS) ? TIME_BITS : sgwp_pkg::GAP_BITS;

   // sequencer codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_BS_RD  = 3'd1;   // issue read of search midpoint
   localparam logic [2:0] ST_BS_CMP = 3'd2;   // narrow the search interval
   localparam logic [2:0] ST_NB_A   = 3'd3;   // edge cases, read right neighbor
   localparam logic [2:0] ST_NB_B   = 3'd4;   // right distance, read left neighbor
   localparam logic [2:0] ST_NB_C   = 3'd5;   // pick nearer neighbor
   localparam logic [2:0] ST_JSCAN  = 3'd6;   // pipelined jump window scan
   localparam logic [2:0] ST_OUT    = 3'd7;   // load the response register

   // tables
   logic [TIME_BITS-1:0] state_mem  [STATE_DEPTH];
   logic [TIME_BITS-1:0] jstart_mem [JUMP_DEPTH];
   logic [TIME_BITS-1:0] jend_mem   [JUMP_DEPTH];
   logic [TIME_BITS-1:0] state_q_ff;
   logic [TIME_BITS-1:0] jstart_q_ff;
   logic [TIME_BITS-1:0] jend_q_ff;
   logic [SB-1:0]        state_addr;

   // configuration
   logic                               enable_ff;
   logic [sgwp_pkg::GAP_BITS-1:0]      min_gap_ff;
   logic [IB-1:0]                      first_idx_ff;

   // stream tracking
   logic [FB-1:0]        state_fill_ff;
   logic [JF-1:0]        jump_fill_ff;
   logic                 have_anchor_ff;
   logic [TIME_BITS-1:0] anchor_time_ff;
   logic [IB-1:0]        anchor_sample_ff;
   logic [IB-1:0]        sample_cnt_ff;
   logic [IB-1:0]        rejected_ff;
   logic [IB-1:0]        window_cnt_ff;

   // planning job
   logic [2:0]           seq_ff, seq_in;
   logic                 pass_ff;              // 0 searching pre time, 1 post time
   logic [TIME_BITS-1:0] pre_time_ff, post_time_ff, key_time;
   logic [IB-1:0]        pre_sample_ff, post_sample_ff, rej_between_ff;
   logic [FB-1:0]        lo_ff, hi_ff, mid_ff, ps_ff;
   logic [TIME_BITS-1:0] dist_hi_ff;
   logic [JF-1:0]        jcnt_ff;
   logic                 jv_ff;
   logic [JF-1:0]        ovl_ff;

   // response register
   logic                       rsp_valid_ff;
   logic [IB-1:0]              rsp_wn_ff, rsp_pre_s_ff, rsp_post_s_ff, rsp_rej_ff;
   logic [TIME_BITS-1:0]       rsp_pre_t_ff, rsp_post_t_ff, rsp_gap_ff;
   logic [FB-1:0]              rsp_ps_ff, rsp_qs_ff, rsp_int_ff;
   logic [JF-1:0]              rsp_ovl_ff;
   logic                       rsp_plan_ff;

   // handshakes
   logic req_acc, rsp_acc, csr_acc;
   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid && csr_ready;
   assign req_stall = (seq_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid_ff && !rsp_stall;

   // sample decode at accept
   logic                 is_sample, is_anchor, gap_ok, start_job;
   logic [IB-1:0]        sample_idx;
   logic [TIME_BITS-1:0] gap_now;
   assign is_sample  = req_acc && (req_func == sgwp_pkg::FUNC_SAMPLE);
   assign is_anchor  = is_sample && req_sample_usable && req_time_valid;
   assign sample_idx = first_idx_ff + sample_cnt_ff;
   assign gap_now    = req_item_time - anchor_time_ff;
   assign gap_ok     = (req_item_time >= anchor_time_ff) &&
                       (CW'(gap_now) >= CW'(min_gap_ff));
   assign start_job  = is_anchor && have_anchor_ff && enable_ff &&
                       (state_fill_ff != '0) && gap_ok;

   // search helpers
   logic [FB-1:0]        mid_calc, res_calc, lo_m1;
   logic [TIME_BITS-1:0] dist_lo;
   assign key_time = pass_ff ? post_time_ff : pre_time_ff;
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_m1    = lo_ff - 1'b1;
   assign dist_lo  = (key_time >= state_q_ff) ? key_time - state_q_ff : state_q_ff - key_time;
   assign res_calc = (dist_hi_ff < dist_lo) ? lo_ff : lo_m1;

   // jump window overlap test on the registered read
   logic jhit;
   assign jhit = jv_ff && !(jend_q_ff < jstart_q_ff) &&
                 (pre_time_ff <= jend_q_ff) && (jstart_q_ff <= post_time_ff);

   // state memory read address
   always_comb begin
      unique case (seq_ff)
         ST_NB_A: state_addr = lo_ff[SB-1:0];
         ST_NB_B: state_addr = lo_m1[SB-1:0];
         default: state_addr = mid_calc[SB-1:0];
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (req_acc && (req_func == sgwp_pkg::FUNC_STATE) && (state_fill_ff < FB'(STATE_DEPTH)))
         state_mem[state_fill_ff[SB-1:0]] <= req_item_time;
      if (req_acc && (req_func == sgwp_pkg::FUNC_JUMP) && (jump_fill_ff < JF'(JUMP_DEPTH))) begin
         jstart_mem[jump_fill_ff[JB-1:0]] <= req_item_time;
         jend_mem[jump_fill_ff[JB-1:0]]   <= req_window_end;
      end
      state_q_ff  <= state_mem[state_addr];
      jstart_q_ff <= jstart_mem[jcnt_ff[JB-1:0]];
      jend_q_ff   <= jend_mem[jcnt_ff[JB-1:0]];
   end

   // sequencer next state
   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         ST_IDLE:   if (start_job) seq_in = ST_BS_RD;
         ST_BS_RD:  seq_in = (lo_ff < hi_ff) ? ST_BS_CMP : ST_NB_A;
         ST_BS_CMP: seq_in = ST_BS_RD;
         ST_NB_A: begin
            if ((lo_ff == '0) || (lo_ff >= state_fill_ff))
               seq_in = pass_ff ? ST_JSCAN : ST_BS_RD;
            else
               seq_in = ST_NB_B;
         end
         ST_NB_B:   seq_in = ST_NB_C;
         ST_NB_C:   seq_in = pass_ff ? ST_JSCAN : ST_BS_RD;
         ST_JSCAN:  if (!(jcnt_ff < jump_fill_ff) && !jv_ff) seq_in = ST_OUT;
         ST_OUT:    if (!rsp_valid_ff || rsp_acc) seq_in = ST_IDLE;
         default:   seq_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff           <= ST_IDLE;
         enable_ff        <= 1'b0;
         min_gap_ff       <= '0;
         first_idx_ff     <= '0;
         state_fill_ff    <= '0;
         jump_fill_ff     <= '0;
         have_anchor_ff   <= 1'b0;
         anchor_time_ff   <= '0;
         anchor_sample_ff <= '0;
         sample_cnt_ff    <= '0;
         rejected_ff      <= '0;
         window_cnt_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
         jv_ff            <= 1'b0;
         pass_ff          <= 1'b0;
      end else begin
         seq_ff <= seq_in;

         if (csr_acc) begin
            unique case (csr_index)
               sgwp_pkg::CSR_ENABLE:    enable_ff    <= csr_data[0];
               sgwp_pkg::CSR_MIN_GAP:   min_gap_ff   <= csr_data[sgwp_pkg::GAP_BITS-1:0];
               sgwp_pkg::CSR_FIRST_IDX: first_idx_ff <= csr_data[IB-1:0];
               default: ;
            endcase
         end

         // table fills
         if (req_acc && (req_func == sgwp_pkg::FUNC_STATE) && (state_fill_ff < FB'(STATE_DEPTH)))
            state_fill_ff <= state_fill_ff + 1'b1;
         if (req_acc && (req_func == sgwp_pkg::FUNC_JUMP) && (jump_fill_ff < JF'(JUMP_DEPTH)))
            jump_fill_ff <= jump_fill_ff + 1'b1;

         // sample stream tracking, the old anchor moves into the job registers
         if (is_sample) begin
            sample_cnt_ff <= sample_cnt_ff + 1'b1;
            if (!req_sample_usable && (rejected_ff != '1))
               rejected_ff <= rejected_ff + 1'b1;
         end
         if (is_anchor) begin
            have_anchor_ff   <= 1'b1;
            anchor_time_ff   <= req_item_time;
            anchor_sample_ff <= sample_idx;
            rejected_ff      <= '0;
         end
         if (start_job) begin
            pre_time_ff    <= anchor_time_ff;
            post_time_ff   <= req_item_time;
            pre_sample_ff  <= anchor_sample_ff;
            post_sample_ff <= sample_idx;
            rej_between_ff <= rejected_ff;
            pass_ff        <= 1'b0;
            lo_ff          <= '0;
            hi_ff          <= state_fill_ff;
            jcnt_ff        <= '0;
            jv_ff          <= 1'b0;
            ovl_ff         <= '0;
         end

         // pre state index lands in ps_ff, post state index in mid_ff
         unique case (seq_ff)
            ST_BS_RD: mid_ff <= mid_calc;
            ST_BS_CMP: begin
               if (state_q_ff < key_time)
                  lo_ff <= mid_ff + 1'b1;
               else
                  hi_ff <= mid_ff;
            end
            ST_NB_A: begin
               if ((lo_ff == '0) || (lo_ff >= state_fill_ff)) begin
                  if (!pass_ff) begin
                     ps_ff   <= (lo_ff == '0) ? '0 : state_fill_ff - 1'b1;
                     pass_ff <= 1'b1;
                     lo_ff   <= '0;
                     hi_ff   <= state_fill_ff;
                  end else begin
                     mid_ff  <= (lo_ff == '0) ? '0 : state_fill_ff - 1'b1;
                  end
               end
            end
            ST_NB_B: dist_hi_ff <= dist_lo;   // distance to the right neighbor
            ST_NB_C: begin
               if (!pass_ff) begin
                  ps_ff   <= res_calc;
                  pass_ff <= 1'b1;
                  lo_ff   <= '0;
                  hi_ff   <= state_fill_ff;
               end else begin
                  mid_ff  <= res_calc;
               end
            end
            ST_JSCAN: begin
               if (jhit)
                  ovl_ff <= ovl_ff + 1'b1;
               if (jcnt_ff < jump_fill_ff) begin
                  jcnt_ff <= jcnt_ff + 1'b1;
                  jv_ff   <= 1'b1;
               end else begin
                  jv_ff <= 1'b0;
               end
            end
            default: ;
         endcase

         // response register
         if ((seq_ff == ST_OUT) && (!rsp_valid_ff || rsp_acc)) begin
            rsp_valid_ff  <= 1'b1;
            window_cnt_ff <= window_cnt_ff + 1'b1;
         end else if (rsp_acc) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // response payload, post state index waits in mid_ff
   logic [FB:0] ps_p1;
   logic        planned_calc;
   assign ps_p1        = {1'b0, ps_ff} + 1'b1;
   assign planned_calc = ({1'b0, mid_ff} > ps_p1);

   always_ff @(posedge clock) begin
      if ((seq_ff == ST_OUT) && (!rsp_valid_ff || rsp_acc)) begin
         rsp_wn_ff     <= window_cnt_ff;
         rsp_pre_s_ff  <= pre_sample_ff;
         rsp_post_s_ff <= post_sample_ff;
         rsp_pre_t_ff  <= pre_time_ff;
         rsp_post_t_ff <= post_time_ff;
         rsp_gap_ff    <= post_time_ff - pre_time_ff;
         rsp_ps_ff     <= ps_ff;
         rsp_qs_ff     <= mid_ff;
         rsp_rej_ff    <= rej_between_ff;
         rsp_ovl_ff    <= ovl_ff;
         rsp_plan_ff   <= planned_calc ? sgwp_pkg::PLANNED : sgwp_pkg::NOT_PLANNED;
         rsp_int_ff    <= planned_calc ? (mid_ff - ps_ff - 1'b1) : '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_window_number    = rsp_wn_ff;
   assign rsp_pre_sample       = rsp_pre_s_ff;
   assign rsp_post_sample      = rsp_post_s_ff;
   assign rsp_pre_time         = rsp_pre_t_ff;
   assign rsp_post_time        = rsp_post_t_ff;
   assign rsp_gap_length       = rsp_gap_ff;
   assign rsp_pre_state        = sgwp_pkg::STATE_OUT_BITS'(rsp_ps_ff);
   assign rsp_post_state       = sgwp_pkg::STATE_OUT_BITS'(rsp_qs_ff);
   assign rsp_rejected_between = rsp_rej_ff;
   assign rsp_overlap_count    = sgwp_pkg::OVERLAP_BITS'(rsp_ovl_ff);
   assign rsp_planned          = rsp_plan_ff;
   assign rsp_interior_count   = sgwp_pkg::STATE_OUT_BITS'(rsp_int_ff);

endmodule
